// ----- sv/scr_pkg.sv -----
// ----------------------------------------------------------------------------
// scr_pkg: shared types and constants of the srgb contrast ratio unit
// sRGB-to-linear table, luminance weights and the beat types that travel
// between the luminance lanes, the divider cells and the output stage
// ----------------------------------------------------------------------------
package scr_pkg;

    localparam int LUM_W = 17;
    localparam int QUO_W = 13;
    localparam int DEN_W = 17;
    localparam int ROM_DEPTH = 256;

    localparam logic [LUM_W-1:0] LUM_MAX  = 17'd65536;
    localparam logic [LUM_W-1:0] LUM_BIAS = 17'd3277;

    localparam logic [15:0] WEIGHT_R = 16'd13933;
    localparam logic [15:0] WEIGHT_G = 16'd46872;
    localparam logic [15:0] WEIGHT_B = 16'd4732;

    // last code on the linear segment of the transfer curve
    localparam int LIN_LAST    = 10;
    localparam int LIN_SLOPE   = 1310720;
    localparam int LIN_HALF    = 32946;
    localparam int LIN_DIVISOR = 65892;

    typedef logic [LUM_W-1:0] t_lum;
    typedef t_lum t_lin_rom [ROM_DEPTH];

    typedef struct packed {
        t_lum lum_a;
        logic is_dark;
    } t_side;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] word;
        logic [DEN_W-1:0] den;
        t_side            side;
    } t_div_beat;

    typedef struct packed {
        t_lum             lum_a;
        logic             is_dark;
        logic [QUO_W-1:0] ratio;
    } t_result;

    // evaluated at elaboration only
    function automatic t_lin_rom build_lin_rom();
        t_lin_rom rom;
        real      x;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            if (k <= LIN_LAST) begin
                rom[k] = LUM_W'((LIN_SLOPE * k + LIN_HALF) / LIN_DIVISOR);
            end else begin
                x = real'(1000 * k + 14025) / 269025.0;
                rom[k] = LUM_W'(int'(65536.0 * (x ** 2.4)));
            end
        end
        return rom;
    endfunction

endpackage

// ----- sv/scr_luma.sv -----
// ----------------------------------------------------------------------------
// scr_luma: relative luminance lane
// table lookup of the three channels, weighting, sum and saturation over
// three register stages
// ----------------------------------------------------------------------------
module scr_luma (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [23:0]       i_colour,
    output scr_pkg::t_lum     o_luminance
);

    localparam scr_pkg::t_lin_rom LIN_ROM = scr_pkg::build_lin_rom();

    scr_pkg::t_lum r_red;
    scr_pkg::t_lum r_grn;
    scr_pkg::t_lum r_blu;
    logic [32:0]   r_prod_r;
    logic [32:0]   r_prod_g;
    logic [32:0]   r_prod_b;
    scr_pkg::t_lum r_lum;

    logic [32:0]   n_sum;
    scr_pkg::t_lum n_shift;
    scr_pkg::t_lum n_lum;

    always_comb begin
        n_sum   = r_prod_r + r_prod_g + r_prod_b;
        n_shift = n_sum[32:16];
        n_lum   = (n_shift > scr_pkg::LUM_MAX) ? scr_pkg::LUM_MAX : n_shift;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red    <= LIN_ROM[i_colour[23:16]];
            r_grn    <= LIN_ROM[i_colour[15:8]];
            r_blu    <= LIN_ROM[i_colour[7:0]];
            r_prod_r <= {16'b0, r_red} * {17'b0, scr_pkg::WEIGHT_R};
            r_prod_g <= {16'b0, r_grn} * {17'b0, scr_pkg::WEIGHT_G};
            r_prod_b <= {16'b0, r_blu} * {17'b0, scr_pkg::WEIGHT_B};
            r_lum    <= n_lum;
        end
    end

    assign o_luminance = r_lum;

endmodule

// ----- sv/scr_div_cell.sv -----
// ----------------------------------------------------------------------------
// scr_div_cell: one restoring division step
// brings in the next dividend bit, subtracts the divisor when it fits and
// shifts the quotient bit into the word
// ----------------------------------------------------------------------------
module scr_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  scr_pkg::t_div_beat i_beat,
    output logic               o_valid,
    output scr_pkg::t_div_beat o_beat
);

    logic               r_valid;
    scr_pkg::t_div_beat r_beat;

    logic [scr_pkg::DEN_W:0]   n_trial;
    logic [scr_pkg::DEN_W:0]   n_diff;
    logic                      n_fits;
    scr_pkg::t_div_beat        n_beat;

    always_comb begin
        n_trial = {i_beat.rem, i_beat.word[scr_pkg::QUO_W-1]};
        n_diff  = n_trial - {1'b0, i_beat.den};
        n_fits  = n_trial >= {1'b0, i_beat.den};
        n_beat      = i_beat;
        n_beat.rem  = n_fits ? n_diff[scr_pkg::DEN_W-1:0] : n_trial[scr_pkg::DEN_W-1:0];
        n_beat.word = {i_beat.word[scr_pkg::QUO_W-2:0], n_fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ----- sv/scr_skid.sv -----
// ----------------------------------------------------------------------------
// scr_skid: output register with skid slot
// holds the pipeline when a result waits and a second one is already out
// ----------------------------------------------------------------------------
module scr_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  scr_pkg::t_result i_data,
    output logic             o_en,
    output logic             o_valid,
    output scr_pkg::t_result o_data,
    input  logic             i_ready
);

    logic             r_out_valid;
    scr_pkg::t_result r_out;
    logic             r_skid_valid;
    scr_pkg::t_result r_skid;

    logic n_free;
    logic n_in;

    always_comb begin
        n_free = !r_out_valid || i_ready;
        n_in   = i_valid && !r_skid_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (n_free) begin
            r_out_valid  <= r_skid_valid || n_in;
            r_skid_valid <= 1'b0;
        end else if (n_in) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (n_in) begin
            r_skid <= i_data;
        end
    end

    assign o_en    = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ----- sv/srgb_contrast_ratio_unit.sv -----
// ----------------------------------------------------------------------------
// srgb_contrast_ratio_unit: luminance and contrast ratio of two sRGB colours
// two luminance lanes, a prep stage, a chain of thirteen divider cells and
// an output register with a skid slot
//
//   channel   direction  handshake          payload
//   input     in         i_valid/o_ready    i_colour_a, i_colour_b
//   result    out        o_valid/i_ready    o_luminance_a, o_is_dark,
//                                           o_contrast_ratio
//   config    in         psel/penable/...   dark_threshold at byte address 0
//
// one beat per cycle while o_ready is high
// stages: 3 luminance stages, 1 prep stage, 13 divider cells, 1 output
// a stalled result parks in the skid slot and then freezes the whole pipe
// synchronous active-low reset clears valids and sets the threshold to 32768
// ----------------------------------------------------------------------------
module srgb_contrast_ratio_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [23:0] i_colour_a,
    input  logic [23:0] i_colour_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [16:0] o_luminance_a,
    output logic        o_is_dark,
    output logic [12:0] o_contrast_ratio,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_DARK_THRESHOLD = 1'b0;
    localparam logic [16:0] DARK_RESET = 17'd32768;

    scr_pkg::t_lum r_dark_threshold;
    logic [2:0]    r_luma_valid;
    logic          r_prep_valid;
    scr_pkg::t_div_beat r_prep;

    logic          w_en;
    scr_pkg::t_lum w_lum_a;
    scr_pkg::t_lum w_lum_b;
    logic          w_cfg_write;

    scr_pkg::t_lum      n_hi;
    scr_pkg::t_lum      n_lo;
    scr_pkg::t_lum      n_hi_sum;
    scr_pkg::t_div_beat n_prep;

    logic               w_valid [scr_pkg::QUO_W+1];
    scr_pkg::t_div_beat w_beat  [scr_pkg::QUO_W+1];

    scr_pkg::t_result   w_result;
    scr_pkg::t_result   w_out;

    // config port
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_threshold <= DARK_RESET;
        end else if (w_cfg_write && paddr[2] == REG_DARK_THRESHOLD) begin
            r_dark_threshold <= pwdata[16:0];
        end
    end

    assign prdata = (paddr[2] == REG_DARK_THRESHOLD) ?
                    {15'b0, r_dark_threshold} : 32'b0;

    // luminance lanes
    assign o_ready = w_en;

    scr_luma u_luma_a (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_colour    (i_colour_a),
        .o_luminance (w_lum_a)
    );

    scr_luma u_luma_b (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_colour    (i_colour_b),
        .o_luminance (w_lum_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_luma_valid <= '0;
            r_prep_valid <= 1'b0;
        end else if (w_en) begin
            r_luma_valid <= {r_luma_valid[1:0], i_valid};
            r_prep_valid <= r_luma_valid[2];
        end
    end

    // prep: order the pair, bias both, split the dividend
    always_comb begin
        n_hi     = (w_lum_a > w_lum_b) ? w_lum_a : w_lum_b;
        n_lo     = (w_lum_a > w_lum_b) ? w_lum_b : w_lum_a;
        n_hi_sum = n_hi + scr_pkg::LUM_BIAS;
        n_prep.rem          = {5'b0, n_hi_sum[16:5]};
        n_prep.word         = {n_hi_sum[4:0], 8'b0};
        n_prep.den          = n_lo + scr_pkg::LUM_BIAS;
        n_prep.side.lum_a   = w_lum_a;
        n_prep.side.is_dark = w_lum_a < r_dark_threshold;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prep <= n_prep;
        end
    end

    // divider chain
    assign w_valid[0] = r_prep_valid;
    assign w_beat[0]  = r_prep;

    for (genvar g = 0; g < scr_pkg::QUO_W; g++) begin : g_cell
        scr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_beat  (w_beat[g]),
            .o_valid (w_valid[g+1]),
            .o_beat  (w_beat[g+1])
        );
    end

    assign w_result.lum_a   = w_beat[scr_pkg::QUO_W].side.lum_a;
    assign w_result.is_dark = w_beat[scr_pkg::QUO_W].side.is_dark;
    assign w_result.ratio   = w_beat[scr_pkg::QUO_W].word;

    scr_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[scr_pkg::QUO_W]),
        .i_data  (w_result),
        .o_en    (w_en),
        .o_valid (o_valid),
        .o_data  (w_out),
        .i_ready (i_ready)
    );

    assign o_luminance_a    = w_out.lum_a;
    assign o_is_dark        = w_out.is_dark;
    assign o_contrast_ratio = w_out.ratio;

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_contrast_ratio >= 13'd256 && o_contrast_ratio <= 13'd5375))
        else $error("contrast ratio out of range");

    a_lum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_luminance_a <= scr_pkg::LUM_MAX)
        else $error("luminance above full scale");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("pipe frozen with no result on the output");

    a_black_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_luminance_a == 17'd0 && r_dark_threshold != 17'd0) |-> o_is_dark)
        else $error("zero luminance not flagged dark");

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: srgb contrast ratio unit
// colour pairs are driven on the input channel and the luminance, dark flag
// and contrast ratio of each result beat are compared with an exact
// fixed-point model kept here (the srgb table is rebuilt with wide integers).
// a directed table covers black, white, primaries, the linear/curve knee and
// equal colours, then random pairs run under a sweep of dark thresholds, each
// setting with or without random gaps on the input side and stalls on the result side
// ----------------------------------------------------------------------------
module testbench;

    localparam int LUM_W = scr_pkg::LUM_W;
    localparam int QUO_W = scr_pkg::QUO_W;
    localparam int PIPE_DEPTH = 18;
    localparam int N_DIR = 20;
    localparam int N_LEVELS = 8;
    localparam int PAIRS_PER_LEVEL = 190;
    localparam int MAX_SHOWN = 40;

    localparam logic [2:0] ADDR_DARK_THRESHOLD = 3'd0;
    localparam logic [LUM_W-1:0] RESET_THRESHOLD = 17'd32768;
    localparam logic [LUM_W-1:0] LUM_FULL = 17'd65536;
    localparam int unsigned AMBIENT = 3277;
    localparam int unsigned KNEE_CODE = 10;
    localparam logic [39:0] W_RED = 40'd13933;
    localparam logic [39:0] W_GRN = 40'd46872;
    localparam logic [39:0] W_BLU = 40'd4732;

    typedef struct packed {
        logic [LUM_W-1:0] lum;
        logic             dark;
        logic [QUO_W-1:0] ratio;
    } t_contrast_beat;

    typedef struct packed {
        logic [23:0]    col_a;
        logic [23:0]    col_b;
        logic           typed;
        t_contrast_beat want;
    } t_row;

    localparam t_contrast_beat NO_WANT = '0;

    localparam t_row DIR_ROWS [N_DIR] = '{
        '{24'h000000, 24'h000000, 1'b1, '{17'd0, 1'b1, 13'd256}},
        '{24'hFFFFFF, 24'hFFFFFF, 1'b1, '{17'd65536, 1'b0, 13'd256}},
        '{24'hFFFFFF, 24'h000000, 1'b1, '{17'd65536, 1'b0, 13'd5375}},
        '{24'h000000, 24'hFFFFFF, 1'b1, '{17'd0, 1'b1, 13'd5375}},
        '{24'hFF0000, 24'h000000, 1'b0, NO_WANT},
        '{24'h00FF00, 24'h000000, 1'b0, NO_WANT},
        '{24'h0000FF, 24'h000000, 1'b0, NO_WANT},
        '{24'h00FF00, 24'hFF00FF, 1'b0, NO_WANT},
        '{24'hFF00FF, 24'h00FF00, 1'b0, NO_WANT},
        '{24'h808080, 24'h808080, 1'b0, NO_WANT},
        '{24'h0A0A0A, 24'h0B0B0B, 1'b0, NO_WANT},
        '{24'h010101, 24'h000000, 1'b0, NO_WANT},
        '{24'h0A0B0C, 24'h0C0B0A, 1'b0, NO_WANT},
        '{24'hFFFFFE, 24'hFFFFFF, 1'b0, NO_WANT},
        '{24'hFEFEFE, 24'h010101, 1'b0, NO_WANT},
        '{24'h555555, 24'hAAAAAA, 1'b0, NO_WANT},
        '{24'hAAAAAA, 24'h555555, 1'b0, NO_WANT},
        '{24'h800000, 24'h008000, 1'b0, NO_WANT},
        '{24'h000080, 24'h123456, 1'b0, NO_WANT},
        '{24'hFFFFFF, 24'h7F7F7F, 1'b0, NO_WANT}
    };

    localparam logic [31:0] LEVELS [N_LEVELS] = '{
        32'd0, 32'd65536, 32'd65537, 32'hFFFF_FFFF,
        32'd1, 32'd32768, 32'd0, 32'd0
    };

    localparam logic [7:0] CORNER_CODES [8] = '{
        8'd0, 8'd1, 8'd10, 8'd11, 8'd12, 8'd128, 8'd254, 8'd255
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [23:0] i_colour_a = '0;
    logic [23:0] i_colour_b = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [16:0] o_luminance_a;
    logic        o_is_dark;
    logic [12:0] o_contrast_ratio;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [LUM_W-1:0] lin_table [256];
    logic [LUM_W-1:0] dark_level = RESET_THRESHOLD;
    t_contrast_beat   want_q [$];
    t_row             row_q [$];
    bit               tx_idle_on = 1'b1;
    bit               rx_idle_on = 1'b1;
    int unsigned      stall_left = 0;
    int unsigned      n_errors = 0;
    int unsigned      n_pairs = 0;
    int unsigned      n_checked = 0;
    int unsigned      n_dark = 0;
    int unsigned      n_settings = 1;

    srgb_contrast_ratio_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_colour_a       (i_colour_a),
        .i_colour_b       (i_colour_b),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_luminance_a    (o_luminance_a),
        .o_is_dark        (o_is_dark),
        .o_contrast_ratio (o_contrast_ratio),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // exact rounding: largest m with (2m-1)^5 * den^12 <= 2^85 * num^12
    function automatic logic [LUM_W-1:0] decode_srgb_code(int unsigned code);
        logic [383:0] rhs;
        logic [383:0] dpow;
        logic [383:0] lhs;
        logic [31:0]  num;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        if (code <= KNEE_CODE) begin
            return LUM_W'((1310720 * code + 32946) / 65892);
        end
        num = 1000 * code + 14025;
        rhs = 384'd1;
        dpow = 384'd1;
        for (int i = 0; i < 12; i++) begin
            rhs = rhs * num;
            dpow = dpow * 384'd269025;
        end
        rhs = rhs << 85;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            lhs = dpow;
            for (int i = 0; i < 5; i++) begin
                lhs = lhs * 384'(2 * mid - 1);
            end
            if (lhs <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return LUM_W'(lo);
    endfunction

    function automatic logic [LUM_W-1:0] luma_of(logic [23:0] colour);
        logic [39:0] acc;
        acc = W_RED * 40'(lin_table[colour[23:16]]) + W_GRN * 40'(lin_table[colour[15:8]])
            + W_BLU * 40'(lin_table[colour[7:0]]);
        acc = acc >> 16;
        return (acc > 40'(LUM_FULL)) ? LUM_FULL : acc[LUM_W-1:0];
    endfunction

    function automatic t_contrast_beat predict_contrast(logic [23:0] ca, logic [23:0] cb);
        t_contrast_beat beat;
        logic [LUM_W-1:0] la;
        logic [LUM_W-1:0] lb;
        int unsigned brighter;
        int unsigned dimmer;
        int unsigned ratio;
        la = luma_of(ca);
        lb = luma_of(cb);
        brighter = (la > lb) ? la : lb;
        dimmer = (la > lb) ? lb : la;
        ratio = ((brighter + AMBIENT) * 256) / (dimmer + AMBIENT);
        beat.lum = la;
        beat.dark = (la < dark_level);
        beat.ratio = ratio[QUO_W-1:0];
        return beat;
    endfunction

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 15) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [7:0] random_chan();
        if ($urandom_range(0, 1) == 0) begin
            return CORNER_CODES[$urandom_range(0, 7)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [23:0] random_colour();
        logic [7:0] grey;
        case ($urandom_range(0, 3))
            0: begin
                grey = random_chan();
                return {grey, grey, grey};
            end
            1: begin
                return {random_chan(), random_chan(), random_chan()};
            end
            default: begin
                return 24'($urandom());
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got_v,
                                   input int unsigned want_v);
        n_errors++;
        if (n_errors <= MAX_SHOWN) begin
            $display("mismatch on %s at result %0d: got %0d, expected %0d",
                     what, n_checked, got_v, want_v);
        end
    endtask

    task automatic send_pair(input logic [23:0] ca, input logic [23:0] cb);
        int unsigned gap;
        gap = tx_idle_on ? gap_len() : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_colour_a <= ca;
        i_colour_b <= cb;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_DARK_THRESHOLD;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        dark_level = data[LUM_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_check(input logic [LUM_W-1:0] want_v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_DARK_THRESHOLD;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== 32'(want_v)) begin
            report_mismatch("threshold readback", prdata, want_v);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle(input int unsigned drain);
        @(posedge i_clk);
        while (want_q.size() != 0 || row_q.size() != 0) @(posedge i_clk);
        repeat (drain) @(posedge i_clk);
    endtask

    // result side stalls
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!rx_idle_on) begin
            i_ready <= 1'b1;
        end else if (i_ready) begin
            if ($urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                stall_left <= gap_len();
            end
        end else begin
            i_ready <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end
    end

    // expectation on each input beat, comparison on each result beat
    always @(posedge i_clk) begin
        t_contrast_beat got_beat;
        t_contrast_beat want_beat;
        t_row           row;
        if (i_rst_n && i_valid && o_ready) begin
            n_pairs++;
            want_beat = predict_contrast(i_colour_a, i_colour_b);
            if (row_q.size() != 0) begin
                row = row_q.pop_front();
                if (row.typed) begin
                    want_beat = row.want;
                end
            end
            want_q.push_back(want_beat);
        end
        if (i_rst_n && o_valid && i_ready) begin
            got_beat = '{o_luminance_a, o_is_dark, o_contrast_ratio};
            if (got_beat.dark) begin
                n_dark++;
            end
            if (want_q.size() == 0) begin
                report_mismatch("unexpected result beat", got_beat.ratio, 0);
            end else begin
                want_beat = want_q.pop_front();
                if (got_beat.lum !== want_beat.lum) begin
                    report_mismatch("luminance_a", got_beat.lum, want_beat.lum);
                end
                if (got_beat.dark !== want_beat.dark) begin
                    report_mismatch("is_dark", got_beat.dark, want_beat.dark);
                end
                if (got_beat.ratio !== want_beat.ratio) begin
                    report_mismatch("contrast_ratio", got_beat.ratio, want_beat.ratio);
                end
            end
            n_checked++;
        end
    end

    initial begin
        logic [23:0] ca;
        logic [23:0] cb;
        logic [31:0] level;
        for (int k = 0; k < 256; k++) begin
            lin_table[k] = decode_srgb_code(k);
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_check(RESET_THRESHOLD);

        for (int r = 0; r < N_DIR; r++) begin
            row_q.push_back(DIR_ROWS[r]);
            send_pair(DIR_ROWS[r].col_a, DIR_ROWS[r].col_b);
        end
        i_valid <= 1'b0;
        settle(0);

        for (int p = 0; p < N_LEVELS; p++) begin
            case (p)
                6: level = 32'($urandom_range(0, 65536));
                7: level = $urandom();
                default: level = LEVELS[p];
            endcase
            apb_write(level);
            apb_check(level[LUM_W-1:0]);
            n_settings++;
            tx_idle_on = (p % 4 != 1) && (p % 4 != 3);
            rx_idle_on = (p % 4 != 2) && (p % 4 != 3);
            for (int n = 0; n < PAIRS_PER_LEVEL; n++) begin
                ca = random_colour();
                cb = ($urandom_range(0, 7) == 0) ? ca : random_colour();
                send_pair(ca, cb);
            end
            i_valid <= 1'b0;
            settle(0);
        end

        settle(PIPE_DEPTH + 6);
        $display("%0d colour pairs driven, %0d result beats compared, %0d threshold settings",
                 n_pairs, n_checked, n_settings);
        $display("%0d results flagged dark, %0d mismatches", n_dark, n_errors);
        if (n_errors == 0 && want_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d result beats outstanding", want_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
